// File: src/wspid_pkg.sv
// Shared widths, register codes, reset values and command types of the wheel speed controller.
package wspid_pkg;

   localparam int TICK_W      = 16;
   localparam int TARGET_W    = 14;
   localparam int GAIN_W      = 10;
   localparam int SLEW_W      = 8;
   localparam int SCALE_W     = 16;
   localparam int DUTY_W      = 7;
   localparam int CMD_W       = 8;
   localparam int ERR_W       = 16;
   localparam int DERR_W      = 17;
   localparam int SUM_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int PROD_W  = 44;
   localparam int ACC_W   = 44;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET     = 10'd50;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET     = 10'd15;
   localparam logic [GAIN_W-1:0]  GAIN_D_RESET     = 10'd30;
   localparam logic [SLEW_W-1:0]  SLEW_STEP_RESET  = 8'd10;
   localparam logic [SCALE_W-1:0] TICK_SCALE_RESET = 16'd6687;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P     = 3'd0,
      CSR_GAIN_I     = 3'd1,
      CSR_GAIN_D     = 3'd2,
      CSR_SLEW_STEP  = 3'd3,
      CSR_TICK_SCALE = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_TICK = 2'd0,
      MUL_P    = 2'd1,
      MUL_I    = 2'd2,
      MUL_D    = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        ld_in;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        err_en;
      logic        sum_en;
      logic        acc_load;
      logic        acc_add;
      logic        cmd_en;
      logic        commit;
   } dp_cmd_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [SLEW_W-1:0]  slew_step;
      logic [SCALE_W-1:0] tick_scale;
   } cfg_type;

endpackage

// File: src/wspid_csr.sv
// Configuration registers of the wheel speed controller with their reset values.
module wspid_csr
   import wspid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= GAIN_P_RESET;
         cfg_ff.gain_i     <= GAIN_I_RESET;
         cfg_ff.gain_d     <= GAIN_D_RESET;
         cfg_ff.slew_step  <= SLEW_STEP_RESET;
         cfg_ff.tick_scale <= TICK_SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:     cfg_ff.gain_p     <= csr_data[GAIN_W-1:0];
            CSR_GAIN_I:     cfg_ff.gain_i     <= csr_data[GAIN_W-1:0];
            CSR_GAIN_D:     cfg_ff.gain_d     <= csr_data[GAIN_W-1:0];
            CSR_SLEW_STEP:  cfg_ff.slew_step  <= csr_data[SLEW_W-1:0];
            CSR_TICK_SCALE: cfg_ff.tick_scale <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/wspid_ctrl.sv
// Sequencing state machine of the wheel speed controller.
module wspid_ctrl
   import wspid_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAS,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACCUM,
      ST_CMD,
      ST_FIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MEAS;
               end
            end
            ST_MEAS:  state_ff <= ST_ERR;
            ST_ERR:   state_ff <= ST_MUL_P;
            ST_MUL_P: state_ff <= ST_MUL_I;
            ST_MUL_I: state_ff <= ST_MUL_D;
            ST_MUL_D: state_ff <= ST_ACCUM;
            ST_ACCUM: state_ff <= ST_CMD;
            ST_CMD:   state_ff <= ST_FIN;
            ST_FIN: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_TICK;
      case (state_ff)
         ST_IDLE: cmd.ld_in = req_valid;
         ST_MEAS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_TICK;
         end
         ST_ERR: cmd.err_en = 1'b1;
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_P;
            cmd.sum_en  = 1'b1;
         end
         ST_MUL_I: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_I;
            cmd.acc_load = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_D;
            cmd.acc_add = 1'b1;
         end
         ST_ACCUM: cmd.acc_add = 1'b1;
         ST_CMD:   cmd.cmd_en  = 1'b1;
         ST_FIN:   cmd.commit  = out_free;
         default: ;
      endcase
   end

endmodule

// File: src/wspid_dp.sv
// Datapath of the wheel speed controller: shared multiplier, error sum, PID accumulator and slew limiter.
module wspid_dp
   import wspid_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   input  cfg_type                    cfg,
   input  logic signed [TICK_W-1:0]   req_tick_count,
   input  logic signed [TARGET_W-1:0] req_target_speed,
   output logic [DUTY_W-1:0]          rsp_duty,
   output logic                       rsp_forward,
   output logic signed [CMD_W-1:0]    rsp_clamped_command
);

   localparam logic signed [25:0]    ERR_HI  = 26'sd32767;
   localparam logic signed [25:0]    ERR_LO  = -26'sd32768;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [35:0]    CMD_HI  = 36'sd100;
   localparam logic signed [35:0]    CMD_LO  = -36'sd100;

   logic signed [TICK_W-1:0]   tick_ff;
   logic signed [TARGET_W-1:0] target_ff;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_full;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [32:0]         meas_adj;
   logic signed [24:0]         measured;
   logic signed [25:0]         diff;
   logic signed [ERR_W-1:0]    err_in;
   logic signed [ERR_W-1:0]    err_ff;
   logic signed [32:0]         sum_wide;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [DERR_W-1:0]   derr_in;
   logic signed [DERR_W-1:0]   derr_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_adj;
   logic signed [35:0]         quot;
   logic signed [CMD_W-1:0]    cmd_in;
   logic signed [CMD_W-1:0]    cmd_ff;
   logic signed [SUM_W-1:0]    error_sum_ff;
   logic signed [ERR_W-1:0]    prev_err_ff;
   logic signed [CMD_W-1:0]    prev_out_ff;
   logic signed [9:0]          cmd10;
   logic signed [9:0]          prev10;
   logic signed [9:0]          step10;
   logic signed [9:0]          delta;
   logic signed [9:0]          lim10;
   logic signed [CMD_W-1:0]    lim;
   logic signed [CMD_W-1:0]    lim_abs;
   logic [DUTY_W-1:0]          duty_ff;
   logic                       forward_ff;
   logic signed [CMD_W-1:0]    clamped_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_TICK: begin
            mul_a = {1'b0, cfg.tick_scale};
            mul_b = {{(MUL_B_W-TICK_W){tick_ff[TICK_W-1]}}, tick_ff};
         end
         MUL_P: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain_p};
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         MUL_I: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain_i};
            mul_b = {{(MUL_B_W-SUM_W){sum_ff[SUM_W-1]}}, sum_ff};
         end
         MUL_D: begin
            mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain_d};
            mul_b = {{(MUL_B_W-DERR_W){derr_ff[DERR_W-1]}}, derr_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Division by 256 rounds toward zero, so negative values are biased first.
   assign meas_adj = prod_ff[32:0] + (prod_ff[32] ? 33'sd255 : 33'sd0);
   assign measured = meas_adj[32:8];
   assign diff     = {{(26-TARGET_W){target_ff[TARGET_W-1]}}, target_ff}
                   - {measured[24], measured};

   always_comb begin
      if (diff > ERR_HI) begin
         err_in = ERR_HI[ERR_W-1:0];
      end else if (diff < ERR_LO) begin
         err_in = ERR_LO[ERR_W-1:0];
      end else begin
         err_in = diff[ERR_W-1:0];
      end
   end

   assign sum_wide = {error_sum_ff[SUM_W-1], error_sum_ff}
                   + {{(33-ERR_W){err_ff[ERR_W-1]}}, err_ff};
   assign sum_in   = (sum_wide[32] != sum_wide[31]) ? (sum_wide[32] ? SUM_MIN : SUM_MAX)
                                                    : sum_wide[SUM_W-1:0];
   assign derr_in  = {err_ff[ERR_W-1], err_ff} - {prev_err_ff[ERR_W-1], prev_err_ff};

   assign acc_adj = acc_ff + (acc_ff[ACC_W-1] ? 44'sd255 : 44'sd0);
   assign quot    = acc_adj[ACC_W-1:8];

   always_comb begin
      if (quot > CMD_HI) begin
         cmd_in = CMD_HI[CMD_W-1:0];
      end else if (quot < CMD_LO) begin
         cmd_in = CMD_LO[CMD_W-1:0];
      end else begin
         cmd_in = quot[CMD_W-1:0];
      end
   end

   assign cmd10  = {{2{cmd_ff[CMD_W-1]}}, cmd_ff};
   assign prev10 = {{2{prev_out_ff[CMD_W-1]}}, prev_out_ff};
   assign step10 = {2'b00, cfg.slew_step};
   assign delta  = cmd10 - prev10;

   always_comb begin
      if (delta >= step10) begin
         lim10 = prev10 + step10;
      end else if (delta <= -step10) begin
         lim10 = prev10 - step10;
      end else begin
         lim10 = cmd10;
      end
   end

   assign lim     = lim10[CMD_W-1:0];
   assign lim_abs = lim[CMD_W-1] ? -lim : lim;

   always_ff @(posedge clock) begin
      if (cmd.ld_in) begin
         tick_ff   <= req_tick_count;
         target_ff <= req_target_speed;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_full[PROD_W-1:0];
      end
      if (cmd.err_en) begin
         err_ff <= err_in;
      end
      if (cmd.sum_en) begin
         sum_ff  <= sum_in;
         derr_ff <= derr_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.cmd_en) begin
         cmd_ff <= cmd_in;
      end
      if (cmd.commit) begin
         duty_ff    <= lim_abs[DUTY_W-1:0];
         forward_ff <= !lim[CMD_W-1];
         clamped_ff <= cmd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
         prev_out_ff  <= '0;
      end else if (cmd.commit) begin
         error_sum_ff <= sum_ff;
         prev_err_ff  <= err_ff;
         prev_out_ff  <= lim;
      end
   end

   assign rsp_duty            = duty_ff;
   assign rsp_forward         = forward_ff;
   assign rsp_clamped_command = clamped_ff;

endmodule

// File: src/wheel_speed_pid_with_slew_limit_unit.sv
// Top level of the wheel speed PID controller with output slew limit.
// After a transfer MEAS, ERR, MUL_P, MUL_I, MUL_D, ACCUM and CMD run in order, and
// FIN offers the result once the output is free. Only one item is in work, as the
// single multiplier serves the tick scaling and the three gain products in turn.
// Reset clears the error sum, previous error and previous output, loads the default
// gains and empties the result register; no clearing pass is needed.
module wheel_speed_pid_with_slew_limit_unit
   import wspid_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [TICK_W-1:0]   req_tick_count,
   input  logic signed [TARGET_W-1:0] req_target_speed,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DUTY_W-1:0]          rsp_duty,
   output logic                       rsp_forward,
   output logic signed [CMD_W-1:0]    rsp_clamped_command,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   wspid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wspid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   wspid_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .cfg                 (cfg),
      .req_tick_count      (req_tick_count),
      .req_target_speed    (req_target_speed),
      .rsp_duty            (rsp_duty),
      .rsp_forward         (rsp_forward),
      .rsp_clamped_command (rsp_clamped_command)
   );

endmodule

// File: src/wspid_checker.sv
// Port-level checks of the wheel speed controller and their binding to the top level.
module wspid_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [6:0]        rsp_duty,
   input logic              rsp_forward,
   input logic signed [7:0] rsp_clamped_command
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty)
         && $stable(rsp_forward) && $stable(rsp_clamped_command))
      else $error("stalled result changed or was dropped");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= 7'd100
         && rsp_clamped_command <= 8'sd100 && rsp_clamped_command >= -8'sd100)
      else $error("result outside the command range");

   a_reverse_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_forward |-> rsp_duty != 7'd0)
      else $error("reverse direction with zero duty");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind wheel_speed_pid_with_slew_limit_unit wspid_checker u_wspid_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench of the wheel speed PID controller with output slew limit.
module tb_top
   import wspid_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE_WAIT  = 12;
   localparam int REPORT_LINES = 100;
   localparam int RANDOM_BATCH = 70;
   localparam int WINDUP_ITEMS = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_C = 3'd7;

   localparam longint SUM_HI  = (longint'(1) <<< 31) - 1;
   localparam longint SUM_LO  = -(longint'(1) <<< 31);
   localparam longint ERR_HI  = 32767;
   localparam longint ERR_LO  = -32768;
   localparam longint CMD_MAX = 100;

   typedef struct {
      logic signed [TICK_W-1:0]   ticks;
      logic signed [TARGET_W-1:0] target;
   } sample_type;

   typedef struct {
      logic [DUTY_W-1:0]       duty;
      logic                    forward;
      logic signed [CMD_W-1:0] command;
   } wheel_cmd_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [TICK_W-1:0]   req_tick_count = '0;
   logic signed [TARGET_W-1:0] req_target_speed = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [DUTY_W-1:0]          rsp_duty;
   logic                       rsp_forward;
   logic signed [CMD_W-1:0]    rsp_clamped_command;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // Controller state and register copies kept by the predictor.
   longint gain_p_m, gain_i_m, gain_d_m, slew_m, scale_m;
   longint err_sum_m, prev_err_m, prev_out_m;

   sample_type    pending_samples[$];
   wheel_cmd_type predicted_cmds[$];
   sample_type    next_sample;
   sample_type    drive_sample;
   wheel_cmd_type got_cmd, want_cmd;

   int  send_idle_pct = 22;
   int  recv_idle_pct = 46;
   int  hold_asks = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  mismatch_count = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;

   wheel_speed_pid_with_slew_limit_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_tick_count      (req_tick_count),
      .req_target_speed    (req_target_speed),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_duty            (rsp_duty),
      .rsp_forward         (rsp_forward),
      .rsp_clamped_command (rsp_clamped_command),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic wheel_cmd_type pid_predict(sample_type s);
      longint        measured, err, sum, pid, cmd, delta, lim;
      wheel_cmd_type r;
      measured = (longint'(s.ticks) * scale_m) / 256;
      err      = clip(longint'(s.target) - measured, ERR_LO, ERR_HI);
      sum      = clip(err_sum_m + err, SUM_LO, SUM_HI);
      pid      = gain_p_m * err + gain_i_m * sum + gain_d_m * (err - prev_err_m);
      cmd      = clip(pid / 256, -CMD_MAX, CMD_MAX);
      delta    = cmd - prev_out_m;
      if (delta >= slew_m) begin
         lim = prev_out_m + slew_m;
      end else if (delta <= -slew_m) begin
         lim = prev_out_m - slew_m;
      end else begin
         lim = cmd;
      end
      err_sum_m  = sum;
      prev_err_m = err;
      prev_out_m = lim;
      r.duty    = DUTY_W'(lim < 0 ? -lim : lim);
      r.forward = (lim >= 0);
      r.command = CMD_W'(cmd);
      return r;
   endfunction

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   // Transfers on both channels are seen here, before the edge updates the block.
   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (req_fire) begin
         next_sample.ticks  = req_tick_count;
         next_sample.target = req_target_speed;
         predicted_cmds.push_back(pid_predict(next_sample));
      end
      if (rsp_fire) begin
         got_cmd.duty    = rsp_duty;
         got_cmd.forward = rsp_forward;
         got_cmd.command = rsp_clamped_command;
         if (predicted_cmds.size() == 0) begin
            note_mismatch("result transfer with no command pending");
         end else begin
            want_cmd = predicted_cmds.pop_front();
            if (got_cmd.duty !== want_cmd.duty) begin
               note_mismatch($sformatf("duty %0d, predicted %0d",
                                       got_cmd.duty, want_cmd.duty));
            end
            if (got_cmd.forward !== want_cmd.forward) begin
               note_mismatch($sformatf("forward %0b, predicted %0b",
                                       got_cmd.forward, want_cmd.forward));
            end
            if (got_cmd.command !== want_cmd.command) begin
               note_mismatch($sformatf("clamped command %0d, predicted %0d",
                                       got_cmd.command, want_cmd.command));
            end
         end
      end
      if (req_fire || rsp_fire) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL wheel_speed_pid_with_slew_limit_unit");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_sample = pending_samples.pop_front();
            req_valid        <= 1'b1;
            req_tick_count   <= drive_sample.ticks;
            req_target_speed <= drive_sample.target;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_GAIN_P:     gain_p_m = longint'(data[GAIN_W-1:0]);
         CSR_GAIN_I:     gain_i_m = longint'(data[GAIN_W-1:0]);
         CSR_GAIN_D:     gain_d_m = longint'(data[GAIN_W-1:0]);
         CSR_SLEW_STEP:  slew_m   = longint'(data[SLEW_W-1:0]);
         CSR_TICK_SCALE: scale_m  = longint'(data);
         default: ;
      endcase
   endtask

   task automatic csr_done();
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Fills the bits above a register's width with noise that the block must drop.
   function automatic logic [CSR_DATA_W-1:0] with_noise(int width, int unsigned v);
      logic [CSR_DATA_W-1:0] mask;
      mask = CSR_DATA_W'((32'd1 << width) - 1);
      return (CSR_DATA_W'($urandom) & ~mask) | (CSR_DATA_W'(v) & mask);
   endfunction

   task automatic put_settings(int unsigned gp, int unsigned gi, int unsigned gd,
                               int unsigned slew, int unsigned scale);
      csr_put(CSR_GAIN_P, with_noise(GAIN_W, gp));
      csr_put(CSR_GAIN_I, with_noise(GAIN_W, gi));
      csr_put(CSR_GAIN_D, with_noise(GAIN_W, gd));
      csr_put(CSR_SLEW_STEP, with_noise(SLEW_W, slew));
      csr_put(CSR_TICK_SCALE, CSR_DATA_W'(scale));
      csr_done();
   endtask

   task automatic random_settings();
      int unsigned gp, gi, gd, slew, scale;
      gp    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
      gi    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 7);
      gd    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
      slew  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
      scale = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 65535);
      put_settings(gp, gi, gd, slew, scale);
   endtask

   task automatic add_sample(int ticks, int target);
      sample_type s;
      s.ticks  = TICK_W'(ticks);
      s.target = TARGET_W'(target);
      pending_samples.push_back(s);
   endtask

   task automatic add_random_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         add_sample(int'($urandom), int'($urandom));
      end else if (roll < 70) begin
         add_sample(int'($urandom_range(0, 80)) - 40, int'($urandom_range(0, 2200)) - 1100);
      end else begin
         add_sample(int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 16383)) - 8192);
      end
   endtask

   task automatic wait_idle();
      while (pending_samples.size() != 0 || req_valid || predicted_cmds.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   initial begin
      gain_p_m   = longint'(GAIN_P_RESET);
      gain_i_m   = longint'(GAIN_I_RESET);
      gain_d_m   = longint'(GAIN_D_RESET);
      slew_m     = longint'(SLEW_STEP_RESET);
      scale_m    = longint'(TICK_SCALE_RESET);
      err_sum_m  = 0;
      prev_err_m = 0;
      prev_out_m = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: field extremes, saturated errors and alternating bit patterns.
      add_sample(0, 0);
      add_sample(32767, 8191);
      add_sample(-32768, -8192);
      add_sample(-32768, 8191);
      add_sample(32767, -8192);
      add_sample(1, -1);
      add_sample(-1, 1);
      add_sample(0, 8191);
      add_sample(0, -8192);
      add_sample(16'h5555, 14'h2AAA);
      add_sample(16'hAAAA, 14'h1555);
      wait_idle();

      // Writes to unused register indexes must leave the settings alone.
      csr_put(CSR_SPARE_A, 16'hFFFF);
      csr_put(CSR_SPARE_B, 16'h0000);
      csr_put(CSR_SPARE_C, 16'hFFFF);
      csr_done();
      add_sample(12, 400);
      add_sample(-12, -400);
      wait_idle();

      // A zero slew step freezes the output whatever the command does.
      put_settings(1023, 1023, 1023, 0, 65535);
      add_sample(100, -100);
      add_sample(-32768, 8191);
      add_sample(5, 5);
      wait_idle();

      // A slew step above the command range lets the command straight through.
      put_settings(0, 0, 0, 255, 0);
      add_sample(32767, 8191);
      add_sample(-32768, -8192);
      add_sample(0, 0);
      wait_idle();

      put_settings(1023, 0, 1023, 1, 6687);
      add_sample(0, 8191);
      add_sample(0, -8192);
      add_sample(0, 8191);
      add_sample(0, -8192);
      wait_idle();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 46 : 0;
         recv_idle_pct = (mode == 0) ? 46 : (mode == 1) ? 22 : 0;
         for (int k = 0; k < 3; k++) begin
            random_settings();
            for (int n = 0; n < RANDOM_BATCH; n++) begin
               add_random_sample();
            end
            if (mode == 2 && k == 1) begin
               hold_asks++;
            end
            wait_idle();
         end
      end

      // Push the error sum up hard with saturated errors, then pull it back down.
      put_settings(1, 1023, 1, 10, 65535);
      for (int n = 0; n < WINDUP_ITEMS; n++) begin
         add_sample(-32768, 8191);
      end
      for (int n = 0; n < 10; n++) begin
         add_sample(32767, -8192);
      end
      wait_idle();

      if (predicted_cmds.size() != 0) begin
         note_mismatch($sformatf("%0d commands never returned", predicted_cmds.size()));
      end
      if (mismatch_count == 0) begin
         $display("PASS wheel_speed_pid_with_slew_limit_unit");
      end else begin
         $display("FAIL wheel_speed_pid_with_slew_limit_unit");
      end
      $finish;
   end

endmodule
